// File: hdl/dhlt_pkg.sv
package dhlt_pkg;

  // Angle constants in signed Q9.16 degrees.
  localparam int unsigned Deg90  = 5898240;
  localparam int unsigned Deg180 = 11796480;
  localparam int unsigned Deg270 = 17694720;
  localparam int unsigned Deg360 = 23592960;

  // pi/180 in Q0.30 and the CORDIC gain compensation in Q2.30.
  localparam logic signed [25:0] RadPerDeg  = 26'sd18740330;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // Width of the CORDIC datapath.
  localparam int Cw = 34;

  typedef logic signed [Cw-1:0] cord_t;

  // atan(2^-i) in Q2.30, truncated.
  function automatic logic [31:0] atan_q30(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: hdl/dh_link_transform_top.sv
// Throughput: one link per cycle while the result side is not stalled; every stage is a
// register, with one register per CORDIC iteration.
// A stall on the result side freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears only the stage valid bits; the data registers are not reset.
module dh_link_transform_top #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // twist_angle[25:0], link_length[57:26], link_offset[89:58], joint_angle[115:90], zero
  input  logic [119:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // m11, m12, m13, m14, m21, m22, m23, m24, m32, m33, m34, 32 bits each from bit 0 up
  output logic [351:0] m_axis_tdata
);
  import dhlt_pkg::*;

  localparam int N  = CORDIC_STAGES;
  localparam int Pd = N + 8;

  logic              en;
  logic [Pd-1:0]     vld_q;

  // Lane 0 carries the joint angle, lane 1 the twist angle.
  logic signed [25:0] ang_q [2];
  logic        [24:0] wrp_q [2];
  logic signed [23:0] fld_q [2];
  logic signed [49:0] prd_q [2];
  cord_t              z0_q  [2];
  cord_t              x_q   [2][N];
  cord_t              y_q   [2][N];
  cord_t              z_q   [2][N];
  logic               neg_c [2];
  logic signed [31:0] cl_c  [2];
  logic signed [31:0] cl_s  [2];

  logic signed [31:0] len_q [Pd-2];
  logic signed [31:0] off_q [Pd-1];

  logic signed [31:0] ct_q, st_q, nst_q, nct_q, ca_q, sa_q;
  logic signed [31:0] ct2_q, st2_q, ca2_q, sa2_q;
  logic signed [63:0] p12_q, p13_q, p14_q, p22_q, p23_q, p24_q;
  logic signed [31:0] m11_q, m12_q, m13_q, m14_q, m21_q, m22_q;
  logic signed [31:0] m23_q, m24_q, m32_q, m33_q, m34_q;

  // The whole pipeline advances unless the result register is held.
  assign en            = !vld_q[Pd-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Pd-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Pd-2:0], s_axis_tvalid};
    end
  end

  // Length and offset ride along the pipeline.
  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q[0] <= s_axis_tdata[115:90];
      ang_q[1] <= s_axis_tdata[25:0];
      len_q[0] <= s_axis_tdata[57:26];
      off_q[0] <= s_axis_tdata[89:58];
      for (int k = 1; k < Pd-2; k++) len_q[k] <= len_q[k-1];
      for (int k = 1; k < Pd-1; k++) off_q[k] <= off_q[k-1];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [26:0] a27;
    logic signed [49:0] rnd;
    logic        [25:0] w26;
    logic signed [Cw-1:0] xf, yf;
    logic               neg_q [2:N+4];

    assign a27 = {ang_q[l][25], ang_q[l]};
    assign rnd = prd_q[l] + 50'sd32768;
    assign w26 = {1'b0, wrp_q[l]};
    assign xf  = x_q[l][N-1];
    assign yf  = y_q[l][N-1];
    assign neg_c[l] = neg_q[N+4];

    // Wrap into [0, 360), fold into [-90, 90], scale to radians and round.
    // The fold flag then waits for the end of the CORDIC chain.
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (a27 >= $signed(27'(Deg360))) begin
          wrp_q[l] <= 25'(a27 - $signed(27'(Deg360)));
        end else if (a27 >= 27'sd0) begin
          wrp_q[l] <= 25'(a27);
        end else if (a27 >= -$signed(27'(Deg360))) begin
          wrp_q[l] <= 25'(a27 + $signed(27'(Deg360)));
        end else begin
          wrp_q[l] <= 25'(a27 + $signed(27'(2 * Deg360)));
        end
        if (w26 <= 26'(Deg90)) begin
          fld_q[l] <= 24'(w26);
          neg_q[2] <= 1'b0;
        end else if (w26 < 26'(Deg270)) begin
          fld_q[l] <= 24'($signed(w26) - $signed(26'(Deg180)));
          neg_q[2] <= 1'b1;
        end else begin
          fld_q[l] <= 24'($signed(w26) - $signed(26'(Deg360)));
          neg_q[2] <= 1'b0;
        end
        for (int k = 3; k <= N + 4; k++) neg_q[k] <= neg_q[k-1];
        prd_q[l] <= 50'(fld_q[l]) * 50'(RadPerDeg);
        z0_q[l]  <= Cw'(rnd >>> 16);
      end
    end

    // One register per CORDIC rotation.
    for (genvar j = 0; j < N; j++) begin : g_cord
      cord_t xi, yi, zi, at;
      if (j == 0) begin : g_first
        assign xi = CordicGain;
        assign yi = '0;
        assign zi = z0_q[l];
      end else begin : g_next
        assign xi = x_q[l][j-1];
        assign yi = y_q[l][j-1];
        assign zi = z_q[l][j-1];
      end
      assign at = Cw'(atan_q30(j));
      always_ff @(posedge clk_i) begin
        if (en) begin
          if (!zi[Cw-1]) begin
            x_q[l][j] <= xi - (yi >>> j);
            y_q[l][j] <= yi + (xi >>> j);
            z_q[l][j] <= zi - at;
          end else begin
            x_q[l][j] <= xi + (yi >>> j);
            y_q[l][j] <= yi - (xi >>> j);
            z_q[l][j] <= zi + at;
          end
        end
      end
    end

    // Clamp both outputs to plus or minus one.
    always_comb begin
      if (xf > cord_t'(1 << 30)) cl_c[l] = 32'sd1073741824;
      else if (xf < -cord_t'(1 << 30)) cl_c[l] = -32'sd1073741824;
      else cl_c[l] = 32'(xf);
      if (yf > cord_t'(1 << 30)) cl_s[l] = 32'sd1073741824;
      else if (yf < -cord_t'(1 << 30)) cl_s[l] = -32'sd1073741824;
      else cl_s[l] = 32'(yf);
    end
  end

  // Apply the fold and keep the negated terms needed below.
  always_ff @(posedge clk_i) begin
    if (en) begin
      ct_q  <= neg_c[0] ? -cl_c[0] : cl_c[0];
      st_q  <= neg_c[0] ? -cl_s[0] : cl_s[0];
      nct_q <= neg_c[0] ? cl_c[0] : -cl_c[0];
      nst_q <= neg_c[0] ? cl_s[0] : -cl_s[0];
      ca_q  <= neg_c[1] ? -cl_c[1] : cl_c[1];
      sa_q  <= neg_c[1] ? -cl_s[1] : cl_s[1];
    end
  end

  // Products of the rotation terms and the link length.
  always_ff @(posedge clk_i) begin
    if (en) begin
      p12_q <= 64'(nst_q) * 64'(ca_q);
      p13_q <= 64'(st_q) * 64'(sa_q);
      p14_q <= 64'(len_q[Pd-3]) * 64'(ct_q);
      p22_q <= 64'(ct_q) * 64'(ca_q);
      p23_q <= 64'(nct_q) * 64'(sa_q);
      p24_q <= 64'(len_q[Pd-3]) * 64'(st_q);
      ct2_q <= ct_q;
      st2_q <= st_q;
      ca2_q <= ca_q;
      sa2_q <= sa_q;
    end
  end

  function automatic logic signed [31:0] rnd_q30(input logic signed [63:0] p);
    logic signed [63:0] r;
    r = (p + 64'sd536870912) >>> 30;
    return r[31:0];
  endfunction

  function automatic logic signed [31:0] rnd_sat(input logic signed [63:0] p);
    logic signed [63:0] r;
    r = (p + 64'sd536870912) >>> 30;
    if (r > 64'sd2147483647) return 32'h7FFF_FFFF;
    else if (r < -64'sd2147483648) return 32'h8000_0000;
    else return r[31:0];
  endfunction

  // Result register: rounding and saturation.
  always_ff @(posedge clk_i) begin
    if (en) begin
      m11_q <= ct2_q;
      m12_q <= rnd_q30(p12_q);
      m13_q <= rnd_q30(p13_q);
      m14_q <= rnd_sat(p14_q);
      m21_q <= st2_q;
      m22_q <= rnd_q30(p22_q);
      m23_q <= rnd_q30(p23_q);
      m24_q <= rnd_sat(p24_q);
      m32_q <= sa2_q;
      m33_q <= ca2_q;
      m34_q <= off_q[Pd-2];
    end
  end

  assign m_axis_tdata = {m34_q, m33_q, m32_q, m24_q, m23_q, m22_q, m21_q,
                         m14_q, m13_q, m12_q, m11_q};

  // Checks on the datapath and flow control.
  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow the result stall");
  a_fold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] |-> (fld_q[0] <= 24'sd5898240 && fld_q[0] >= -24'sd5898240))
    else $error("folded angle out of range");
  a_cos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m11_q <= 32'sd1073741824 && m11_q >= -32'sd1073741824))
    else $error("cosine out of range");
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during a stall");

endmodule
